// ===== src/pvsl_pkg.sv =====
package pvsl_pkg;

    // Field and register widths
    localparam int VEL_W      = 16;   // Q4.12 signed velocity
    localparam int ACCEL_W    = 16;   // Q8.8 per second
    localparam int TOL_W      = 15;   // Q3.12 unsigned magnitude
    localparam int DT_W       = 16;   // Q0.16 seconds
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Serial arithmetic units
    localparam int MUL_W      = 16;              // operand width of the shift-add multiplier
    localparam int PROD_W     = 2 * MUL_W;
    localparam int STEP_W     = 15;              // saturated step, max 32767
    localparam int STEP_SHIFT = 12;              // Q8.8 * Q0.16 -> Q4.12
    localparam int ROOT_W     = 17;              // floor(sqrt) of a 34-bit radicand
    localparam int QUO_W      = 15;              // quotient bound: never above the step

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_LIN_ACCEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_ACCEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_TOL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_TOL   = 2'd3;

    localparam logic [ACCEL_W-1:0] ACCEL_RST = 16'd256;

    // Opcodes
    localparam logic OP_STEP   = 1'b0;
    localparam logic OP_PRESET = 1'b1;

    // (accel * dt) >> 12, saturated to the largest step
    function automatic logic [STEP_W-1:0] step_sat(input logic [PROD_W-1:0] p);
        logic over;
        over = |p[PROD_W-1:STEP_W+STEP_SHIFT];
        return over ? {STEP_W{1'b1}} : p[STEP_W+STEP_SHIFT-1:STEP_SHIFT];
    endfunction

endpackage

// ===== src/planar_velocity_slew_limiter.sv =====
// Planar velocity slew limiter. Holds a planar velocity (x, y) and a yaw rate,
// all Q4.12 signed, and on each step request moves them toward the targets by at
// most accel * time_step: the planar move is limited along the change vector
// (snapping to the target when it lies within one step), the yaw move is a
// scalar slew, and afterwards a planar speed or yaw magnitude below its
// tolerance snaps to zero. A preset request loads the state directly and a
// step request with time_step zero returns the state unchanged. Every request
// yields exactly one result carrying the state. Requests are handled one at a
// time: preset and zero-time requests go from accept straight to the result
// stage; a step request runs through the phases of the serial arithmetic,
// and any request is held further while the result side stalls. The serial
// arithmetic is four shift-add multipliers (one bit per cycle), a square
// root unit (two radicand bits per cycle) and two restoring dividers (one
// quotient bit per cycle), run in phases; the dividers run only when the
// move is scaled along the vector rather than snapped to the target.
// A finished result is held in an output register, so the next request is
// accepted while it waits. Configuration registers (index: 0 linear accel,
// 1 angular accel, 2 linear snap tolerance, 3 angular snap tolerance) are
// written through cfg_we/cfg_index/cfg_data and must only change while idle.
module planar_velocity_slew_limiter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic signed [pvsl_pkg::VEL_W-1:0]    target_vx,
    input  logic signed [pvsl_pkg::VEL_W-1:0]    target_vy,
    input  logic signed [pvsl_pkg::VEL_W-1:0]    target_yaw_rate,
    input  logic        [pvsl_pkg::DT_W-1:0]     time_step,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pvsl_pkg::VEL_W-1:0]    vel_x,
    output logic signed [pvsl_pkg::VEL_W-1:0]    vel_y,
    output logic signed [pvsl_pkg::VEL_W-1:0]    yaw_rate,
    // configuration
    input  logic                                 cfg_we,
    input  logic [pvsl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pvsl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int VW = pvsl_pkg::VEL_W;
    localparam int MW = pvsl_pkg::MUL_W;
    localparam int PW = pvsl_pkg::PROD_W;
    localparam int SW = pvsl_pkg::STEP_W;
    localparam int RW = pvsl_pkg::ROOT_W;
    localparam int QW = pvsl_pkg::QUO_W;
    localparam int AW = pvsl_pkg::ACCEL_W;
    localparam int TW = pvsl_pkg::TOL_W;

    // multiplier roles
    localparam int U_LIN = 0;   // linear step, later tolerance squared
    localparam int U_ANG = 1;   // angular step
    localparam int U_X   = 2;   // dx^2, then step*|dx|, then vx^2
    localparam int U_Y   = 3;   // same for y
    localparam int NMUL  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,     // step sizes and squared distance components
        ST_ROOT,     // distance root, step * |d| products
        ST_DIV,      // per-component scaled move
        ST_LAUNCH,   // start speed squares
        ST_SQ,       // speed vs tolerance
        ST_FIN       // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    logic [VW-1:0] held_vx_reg, held_vx_next;
    logic [VW-1:0] held_vy_reg, held_vy_next;
    logic [VW-1:0] held_yaw_reg, held_yaw_next;

    logic [AW-1:0] lin_accel_reg, lin_accel_next;
    logic [AW-1:0] ang_accel_reg, ang_accel_next;
    logic [TW-1:0] lin_tol_reg, lin_tol_next;
    logic [TW-1:0] ang_tol_reg, ang_tol_next;

    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] vel_x_reg, vel_x_next;
    logic [VW-1:0] vel_y_reg, vel_y_next;
    logic [VW-1:0] yaw_rate_reg, yaw_rate_next;

    // per-request working registers, no reset needed
    logic [VW-1:0] tx_reg, tx_next;
    logic [VW-1:0] ty_reg, ty_next;
    logic [VW-1:0] tw_reg, tw_next;
    logic          dx_neg_reg, dx_neg_next;
    logic          dy_neg_reg, dy_neg_next;
    logic [MW-1:0] dx_mag_reg, dx_mag_next;
    logic [MW-1:0] dy_mag_reg, dy_mag_next;
    logic [SW-1:0] ms_reg, ms_next;

    // serial units
    logic [NMUL-1:0] mul_start;
    logic [NMUL-1:0] mul_busy;
    logic [MW-1:0]   mul_a [NMUL];
    logic [MW-1:0]   mul_b [NMUL];
    logic [PW-1:0]   mul_prod [NMUL];

    logic            sqrt_start;
    logic            sqrt_busy;
    logic [2*RW-1:0] sqrt_rad;
    logic [RW-1:0]   sqrt_root;
    logic            sqrt_exact;

    logic            div_start;
    logic [1:0]      div_busy;
    logic [QW-1:0]   quo_x;
    logic [QW-1:0]   quo_y;

    // datapath helpers
    logic          accept;
    logic          units_idle;
    logic [VW:0]   dx_full, dy_full;
    logic [VW:0]   dx_abs, dy_abs;
    logic [SW-1:0] ms_comb, ma_comb;
    logic [VW:0]   dw_full, dw_abs;
    logic [VW-1:0] ma_ext;
    logic [VW-1:0] yaw_mag;
    logic          take_target;
    logic [VW-1:0] qx_ext, qy_ext;
    logic [VW-1:0] vx_mag, vy_mag;
    logic [PW:0]   speed_sq;

    genvar gi;
    generate
        for (gi = 0; gi < NMUL; gi++)
        begin : g_mul
            pvsl_mul #(
                .W (MW)
            ) u_mul (
                .clk   (clk),
                .rst_n (rst_n),
                .start (mul_start[gi]),
                .a     (mul_a[gi]),
                .b     (mul_b[gi]),
                .busy  (mul_busy[gi]),
                .prod  (mul_prod[gi])
            );
        end
    endgenerate

    pvsl_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sqrt_rad),
        .busy  (sqrt_busy),
        .root  (sqrt_root),
        .exact (sqrt_exact)
    );

    // numerators are step * |d| < 2^31, quotient never exceeds the step
    pvsl_div #(
        .DW (RW),
        .QW (QW)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod[U_X]),
        .den   (sqrt_root),
        .busy  (div_busy[0]),
        .quo   (quo_x)
    );

    pvsl_div #(
        .DW (RW),
        .QW (QW)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod[U_Y]),
        .den   (sqrt_root),
        .busy  (div_busy[1]),
        .quo   (quo_y)
    );

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign units_idle = !(|mul_busy) && !sqrt_busy && !(|div_busy);

    always_comb
    begin
        // change vector from the held state, 17-bit two's complement
        dx_full = {target_vx[VW-1], target_vx} - {held_vx_reg[VW-1], held_vx_reg};
        dy_full = {target_vy[VW-1], target_vy} - {held_vy_reg[VW-1], held_vy_reg};
        dx_abs  = dx_full[VW] ? (~dx_full + 1'b1) : dx_full;
        dy_abs  = dy_full[VW] ? (~dy_full + 1'b1) : dy_full;

        ms_comb = pvsl_pkg::step_sat(mul_prod[U_LIN]);
        ma_comb = pvsl_pkg::step_sat(mul_prod[U_ANG]);

        // yaw slew
        dw_full = {tw_reg[VW-1], tw_reg} - {held_yaw_reg[VW-1], held_yaw_reg};
        dw_abs  = dw_full[VW] ? (~dw_full + 1'b1) : dw_full;
        ma_ext  = {{(VW-SW){1'b0}}, ma_comb};
        yaw_mag = held_yaw_reg[VW-1] ? (~held_yaw_reg + 1'b1) : held_yaw_reg;

        // dist2 <= ms^2  <=>  root < ms, or root == ms with no remainder
        take_target = (sqrt_root < {{(RW-SW){1'b0}}, ms_reg})
                   || ((sqrt_root == {{(RW-SW){1'b0}}, ms_reg}) && sqrt_exact);

        qx_ext = {{(VW-QW){1'b0}}, quo_x};
        qy_ext = {{(VW-QW){1'b0}}, quo_y};

        vx_mag   = held_vx_reg[VW-1] ? (~held_vx_reg + 1'b1) : held_vx_reg;
        vy_mag   = held_vy_reg[VW-1] ? (~held_vy_reg + 1'b1) : held_vy_reg;
        speed_sq = {1'b0, mul_prod[U_X]} + {1'b0, mul_prod[U_Y]};

        sqrt_rad = {2'b00, mul_prod[U_X]} + {2'b00, mul_prod[U_Y]};
    end

    always_comb
    begin
        state_next     = state_reg;
        held_vx_next   = held_vx_reg;
        held_vy_next   = held_vy_reg;
        held_yaw_next  = held_yaw_reg;
        lin_accel_next = lin_accel_reg;
        ang_accel_next = ang_accel_reg;
        lin_tol_next   = lin_tol_reg;
        ang_tol_next   = ang_tol_reg;
        out_valid_next = out_valid_reg && out_stall;
        vel_x_next     = vel_x_reg;
        vel_y_next     = vel_y_reg;
        yaw_rate_next  = yaw_rate_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        tw_next        = tw_reg;
        dx_neg_next    = dx_neg_reg;
        dy_neg_next    = dy_neg_reg;
        dx_mag_next    = dx_mag_reg;
        dy_mag_next    = dy_mag_reg;
        ms_next        = ms_reg;
        mul_start      = '0;
        sqrt_start     = 1'b0;
        div_start      = 1'b0;
        for (int i = 0; i < NMUL; i++)
        begin
            mul_a[i] = '0;
            mul_b[i] = '0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                pvsl_pkg::REG_LIN_ACCEL: lin_accel_next = cfg_data[AW-1:0];
                pvsl_pkg::REG_ANG_ACCEL: ang_accel_next = cfg_data[AW-1:0];
                pvsl_pkg::REG_LIN_TOL:   lin_tol_next   = cfg_data[TW-1:0];
                pvsl_pkg::REG_ANG_TOL:   ang_tol_next   = cfg_data[TW-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == pvsl_pkg::OP_PRESET)
                    begin
                        held_vx_next  = target_vx;
                        held_vy_next  = target_vy;
                        held_yaw_next = target_yaw_rate;
                        state_next    = ST_FIN;
                    end
                    else if (time_step == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        tx_next     = target_vx;
                        ty_next     = target_vy;
                        tw_next     = target_yaw_rate;
                        dx_neg_next = dx_full[VW];
                        dy_neg_next = dy_full[VW];
                        dx_mag_next = dx_abs[MW-1:0];
                        dy_mag_next = dy_abs[MW-1:0];
                        mul_start   = '1;
                        mul_a[U_LIN] = lin_accel_reg;
                        mul_b[U_LIN] = time_step;
                        mul_a[U_ANG] = ang_accel_reg;
                        mul_b[U_ANG] = time_step;
                        mul_a[U_X]   = dx_abs[MW-1:0];
                        mul_b[U_X]   = dx_abs[MW-1:0];
                        mul_a[U_Y]   = dy_abs[MW-1:0];
                        mul_b[U_Y]   = dy_abs[MW-1:0];
                        state_next   = ST_MUL1;
                    end
                end
            end

            ST_MUL1:
            begin
                if (units_idle)
                begin
                    ms_next = ms_comb;
                    // yaw moves by at most the angular step
                    if (dw_abs <= {{(VW+1-SW){1'b0}}, ma_comb})
                    begin
                        held_yaw_next = tw_reg;
                    end
                    else if (dw_full[VW])
                    begin
                        held_yaw_next = held_yaw_reg - ma_ext;
                    end
                    else
                    begin
                        held_yaw_next = held_yaw_reg + ma_ext;
                    end
                    sqrt_start            = 1'b1;
                    mul_start[U_X]        = 1'b1;
                    mul_start[U_Y]        = 1'b1;
                    mul_a[U_X]            = {{(MW-SW){1'b0}}, ms_comb};
                    mul_b[U_X]            = dx_mag_reg;
                    mul_a[U_Y]            = {{(MW-SW){1'b0}}, ms_comb};
                    mul_b[U_Y]            = dy_mag_reg;
                    state_next            = ST_ROOT;
                end
            end

            ST_ROOT:
            begin
                if (units_idle)
                begin
                    // yaw deadband
                    if (yaw_mag < {1'b0, ang_tol_reg})
                    begin
                        held_yaw_next = '0;
                    end
                    if (take_target)
                    begin
                        held_vx_next = tx_reg;
                        held_vy_next = ty_reg;
                        state_next   = ST_LAUNCH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (units_idle)
                begin
                    held_vx_next = dx_neg_reg ? (held_vx_reg - qx_ext) : (held_vx_reg + qx_ext);
                    held_vy_next = dy_neg_reg ? (held_vy_reg - qy_ext) : (held_vy_reg + qy_ext);
                    state_next   = ST_LAUNCH;
                end
            end

            ST_LAUNCH:
            begin
                mul_start[U_LIN] = 1'b1;
                mul_start[U_X]   = 1'b1;
                mul_start[U_Y]   = 1'b1;
                mul_a[U_LIN]     = {{(MW-TW){1'b0}}, lin_tol_reg};
                mul_b[U_LIN]     = {{(MW-TW){1'b0}}, lin_tol_reg};
                mul_a[U_X]       = vx_mag;
                mul_b[U_X]       = vx_mag;
                mul_a[U_Y]       = vy_mag;
                mul_b[U_Y]       = vy_mag;
                state_next       = ST_SQ;
            end

            ST_SQ:
            begin
                if (units_idle)
                begin
                    // planar deadband
                    if (speed_sq < {1'b0, mul_prod[U_LIN]})
                    begin
                        held_vx_next = '0;
                        held_vy_next = '0;
                    end
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    vel_x_next     = held_vx_reg;
                    vel_y_next     = held_vy_reg;
                    yaw_rate_next  = held_yaw_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_vx_reg   <= '0;
            held_vy_reg   <= '0;
            held_yaw_reg  <= '0;
            lin_accel_reg <= pvsl_pkg::ACCEL_RST;
            ang_accel_reg <= pvsl_pkg::ACCEL_RST;
            lin_tol_reg   <= '0;
            ang_tol_reg   <= '0;
            out_valid_reg <= 1'b0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            yaw_rate_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            held_vx_reg   <= held_vx_next;
            held_vy_reg   <= held_vy_next;
            held_yaw_reg  <= held_yaw_next;
            lin_accel_reg <= lin_accel_next;
            ang_accel_reg <= ang_accel_next;
            lin_tol_reg   <= lin_tol_next;
            ang_tol_reg   <= ang_tol_next;
            out_valid_reg <= out_valid_next;
            vel_x_reg     <= vel_x_next;
            vel_y_reg     <= vel_y_next;
            yaw_rate_reg  <= yaw_rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        tw_reg     <= tw_next;
        dx_neg_reg <= dx_neg_next;
        dy_neg_reg <= dy_neg_next;
        dx_mag_reg <= dx_mag_next;
        dy_mag_reg <= dy_mag_next;
        ms_reg     <= ms_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign yaw_rate  = yaw_rate_reg;

endmodule

// ===== src/pvsl_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
module pvsl_mul #(
    parameter int W = pvsl_pkg::MUL_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           busy,
    output logic [2*W-1:0] prod
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   mcand_reg, mcand_next;
    logic [W-1:0]   mplier_reg, mplier_next;
    logic [2*W-1:0] acc_reg, acc_next;

    always_comb
    begin
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            cnt_next    = CW'(W);
            mcand_next  = a;
            mplier_next = b;
            acc_next    = '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_next    = {acc_reg[2*W-2:0], 1'b0}
                        + (mplier_reg[W-1] ? {{W{1'b0}}, mcand_reg} : {(2*W){1'b0}});
            mplier_next = {mplier_reg[W-2:0], 1'b0};
            cnt_next    = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

endmodule

// ===== src/pvsl_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
module pvsl_sqrt #(
    parameter int RW = pvsl_pkg::ROOT_W
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] rad,
    output logic            busy,
    output logic [RW-1:0]   root,
    output logic            exact
);

    localparam int CW = $clog2(RW + 1);
    localparam int MW = RW + 3;

    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [MW-1:0]   rem_reg, rem_next;
    logic [MW-1:0]   rem_sh;
    logic [MW-1:0]   trial;

    always_comb
    begin
        // remainder stays below 2^(RW+1), so the top bits drop safely
        rem_sh     = {rem_reg[RW:0], rad_reg[2*RW-1 -: 2]};
        trial      = {1'b0, root_reg, 2'b01};
        cnt_next   = cnt_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            cnt_next  = CW'(RW);
            rad_next  = rad;
            root_next = '0;
            rem_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            rad_next = {rad_reg[2*RW-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign busy  = (cnt_reg != '0);
    assign root  = root_reg;
    assign exact = (rem_reg == '0);

endmodule

// ===== src/pvsl_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Caller guarantees the quotient fits QW bits (num < den << QW).
module pvsl_div #(
    parameter int DW = pvsl_pkg::ROOT_W,
    parameter int QW = pvsl_pkg::QUO_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DW+QW-1:0] num,
    input  logic [DW-1:0]    den,
    output logic             busy,
    output logic [QW-1:0]    quo
);

    localparam int CW = $clog2(QW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;   // dividend bits out, quotient bits in
    logic [DW:0]   rem_sh;
    logic          ge;

    always_comb
    begin
        rem_sh   = {rem_reg, low_reg[QW-1]};
        ge       = (rem_sh >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        low_next = low_reg;
        if (start)
        begin
            cnt_next = CW'(QW);
            den_next = den;
            rem_next = num[DW+QW-1:QW];
            low_next = num[QW-1:0];
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
            low_next = {low_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = low_reg;

endmodule
